FILE: rtl/ppdc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ppdc_pkg;

   localparam int TRIG_ITERATIONS = 16;
   localparam int TABLE_LEN = 24;
   localparam int STEPS = (TRIG_ITERATIONS < TABLE_LEN) ? TRIG_ITERATIONS : TABLE_LEN;

   localparam logic signed [39:0] ANG_PI = 40'sd3373259426;
   localparam logic signed [39:0] ANG_TWO_PI = 40'sd6746518852;
   localparam logic signed [39:0] ANG_HALF_PI = 40'sd1686629713;
   localparam logic signed [33:0] CORDIC_KINV = 34'sd652032874;

   localparam logic [2:0] REG_GAIN_RHO = 3'd0;
   localparam logic [2:0] REG_GAIN_ALPHA = 3'd1;
   localparam logic [2:0] REG_GAIN_BETA = 3'd2;
   localparam logic [2:0] REG_LINEAR_LIMIT = 3'd3;
   localparam logic [2:0] REG_ANGULAR_LIMIT = 3'd4;
   localparam logic [2:0] REG_GOAL_X = 3'd5;
   localparam logic [2:0] REG_GOAL_Y = 3'd6;
   localparam logic [2:0] REG_GOAL_HEADING = 3'd7;

   typedef struct packed {
      logic              active;
      logic signed [23:0] robot_x;
      logic signed [23:0] robot_y;
      logic signed [15:0] robot_heading;
   } req_type;

   typedef struct packed {
      logic signed [23:0] linear_velocity;
      logic signed [23:0] angular_velocity;
      logic              in_deadzone;
      logic              was_scaled;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] gain_rho;
      logic signed [15:0] gain_alpha;
      logic signed [15:0] gain_beta;
      logic [22:0]        linear_limit;
      logic [22:0]        angular_limit;
      logic signed [23:0] goal_x;
      logic signed [23:0] goal_y;
      logic signed [15:0] goal_heading;
   } cfg_type;

   typedef struct packed {
      logic              active;
      logic signed [35:0] theta;
      logic signed [24:0] dx;
      logic signed [24:0] dy;
   } q_entry_type;

   function automatic logic signed [39:0] atan_entry(input logic [4:0] i);
      logic signed [39:0] r;
      case (i)
         5'd0: r = 40'sd843314856;
         5'd1: r = 40'sd497837829;
         5'd2: r = 40'sd263043836;
         5'd3: r = 40'sd133525158;
         5'd4: r = 40'sd67021686;
         5'd5: r = 40'sd33543515;
         5'd6: r = 40'sd16775850;
         5'd7: r = 40'sd8388437;
         5'd8: r = 40'sd4194282;
         5'd9: r = 40'sd2097149;
         5'd10: r = 40'sd1048575;
         5'd11: r = 40'sd524287;
         5'd12: r = 40'sd262143;
         5'd13: r = 40'sd131071;
         5'd14: r = 40'sd65535;
         5'd15: r = 40'sd32767;
         5'd16: r = 40'sd16383;
         5'd17: r = 40'sd8191;
         5'd18: r = 40'sd4095;
         5'd19: r = 40'sd2047;
         5'd20: r = 40'sd1023;
         5'd21: r = 40'sd511;
         5'd22: r = 40'sd255;
         5'd23: r = 40'sd127;
         default: r = 40'sd0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/ppdc_front.sv
`timescale 1ns / 1ps
`default_nettype none
module ppdc_front (
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire ppdc_pkg::req_type     req_data,
   input  wire ppdc_pkg::cfg_type     cfg,
   input  wire logic                  q_full,
   output logic                       push,
   output ppdc_pkg::q_entry_type      entry
);
   import ppdc_pkg::*;

   logic signed [16:0] hdiff;

   assign req_stall = q_full;
   assign push = req_valid & ~q_full;
   assign hdiff = 17'(req_data.robot_heading) - 17'(cfg.goal_heading);

   always_comb begin
      entry.active = req_data.active;
      entry.theta = 36'(hdiff) <<< 18;
      entry.dx = 25'(req_data.robot_x) - 25'(cfg.goal_x);
      entry.dy = 25'(req_data.robot_y) - 25'(cfg.goal_y);
   end
endmodule
`default_nettype wire

FILE: rtl/ppdc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module ppdc_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire ppdc_pkg::q_entry_type push_data,
   input  wire logic                  pop,
   output logic                       full,
   output logic                       not_empty,
   output ppdc_pkg::q_entry_type      head
);
   import ppdc_pkg::*;

   q_entry_type mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign head = mem_ff[rp_ff];

   always_comb begin
      wp_in = wp_ff ^ push;
      rp_in = rp_ff ^ pop;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= push_data;
      end
   end
endmodule
`default_nettype wire

FILE: rtl/ppdc_back.sv
`timescale 1ns / 1ps
`default_nettype none
module ppdc_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ppdc_pkg::cfg_type     cfg,
   input  wire logic                  q_not_empty,
   input  wire ppdc_pkg::q_entry_type q_head,
   output logic                       pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output ppdc_pkg::rsp_type          rsp_data
);
   import ppdc_pkg::*;

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_WRAP = 5'd1;
   localparam logic [4:0] S_SC_FOLD = 5'd2;
   localparam logic [4:0] S_SC_IT = 5'd3;
   localparam logic [4:0] S_SC_END = 5'd4;
   localparam logic [4:0] S_M_CDX = 5'd5;
   localparam logic [4:0] S_M_SDY = 5'd6;
   localparam logic [4:0] S_M_CDY = 5'd7;
   localparam logic [4:0] S_M_SDX = 5'd8;
   localparam logic [4:0] S_M_XX = 5'd9;
   localparam logic [4:0] S_M_YY = 5'd10;
   localparam logic [4:0] S_SQRT = 5'd11;
   localparam logic [4:0] S_DZ = 5'd12;
   localparam logic [4:0] S_AT_IT = 5'd13;
   localparam logic [4:0] S_PARK = 5'd14;
   localparam logic [4:0] S_BETA = 5'd15;
   localparam logic [4:0] S_M_V = 5'd16;
   localparam logic [4:0] S_M_WA = 5'd17;
   localparam logic [4:0] S_M_WB = 5'd18;
   localparam logic [4:0] S_SAT = 5'd19;
   localparam logic [4:0] S_M_LA = 5'd20;
   localparam logic [4:0] S_M_AV = 5'd21;
   localparam logic [4:0] S_M_NUM = 5'd22;
   localparam logic [4:0] S_DIV = 5'd23;
   localparam logic [4:0] S_FIN = 5'd24;

   localparam logic [55:0] SQ_START = 56'd1 << 54;
   localparam logic [5:0] DIV_BITS = 6'd57;

   logic [4:0]          st_ff, st_in, ret_ff, ret_in;
   q_entry_type         ent_ff, ent_in;
   logic signed [39:0]  ang_ff, ang_in;
   logic signed [33:0]  cx_ff, cx_in, cy_ff, cy_in, c_ff, c_in, s_ff, s_in;
   logic signed [39:0]  cz_ff, cz_in;
   logic [4:0]          it_ff, it_in;
   logic                flip_ff, flip_in;
   logic signed [67:0]  acc_ff, acc_in;
   logic signed [26:0]  xr_ff, xr_in, yr_ff, yr_in;
   logic [55:0]         sn_ff, sn_in, sr_ff, sr_in, sb_ff, sb_in;
   logic [26:0]         rho_ff, rho_in;
   logic                dz_ff, dz_in;
   logic signed [47:0]  ax_ff, ax_in, ay_ff, ay_in;
   logic signed [39:0]  alpha_ff, alpha_in, beta_ff, beta_in;
   logic                neg_ff, neg_in, usev_ff, usev_in;
   logic signed [35:0]  v_ff, v_in, w_ff, w_in;
   logic [56:0]         quo_ff, quo_in;
   logic [36:0]         rem_ff, rem_in;
   logic [35:0]         den_ff, den_in;
   logic [5:0]          dc_ff, dc_in;
   logic                ov_ff, ov_in;
   rsp_type             out_ff, out_in;

   logic signed [40:0]  mul_a;
   logic signed [26:0]  mul_b;
   logic signed [67:0]  prod, rsum;
   logic signed [39:0]  tab, neg_theta, alpha_w;
   logic [35:0]         av, aw;
   logic                last_it, dz_new;
   logic signed [47:0]  ax0, ay0;
   logic [55:0]         sq_try;
   logic [36:0]         rem_sh;
   logic signed [35:0]  quo_s;

   assign tab = atan_entry(it_ff);
   assign last_it = (it_ff == 5'(STEPS - 1));
   assign neg_theta = -40'(ent_ff.theta);
   assign av = 36'(v_ff[35] ? -v_ff : v_ff);
   assign aw = 36'(w_ff[35] ? -w_ff : w_ff);
   assign prod = mul_a * mul_b;
   assign sq_try = sr_ff + sb_ff;
   assign rem_sh = {rem_ff[35:0], quo_ff[56]};
   assign quo_s = 36'(quo_ff);
   assign ax0 = -(48'(xr_ff) <<< 16);
   assign ay0 = -(48'(yr_ff) <<< 16);
   assign pop = (st_ff == S_IDLE) && q_not_empty && !ov_ff;
   assign rsp_valid = ov_ff;
   assign rsp_data = out_ff;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (st_ff)
         S_M_CDX: begin mul_a = 41'(c_ff); mul_b = 27'(ent_ff.dx); end
         S_M_SDY: begin mul_a = 41'(s_ff); mul_b = 27'(ent_ff.dy); end
         S_M_CDY: begin mul_a = 41'(c_ff); mul_b = 27'(ent_ff.dy); end
         S_M_SDX: begin mul_a = 41'(s_ff); mul_b = 27'(ent_ff.dx); end
         S_M_XX: begin mul_a = 41'(xr_ff); mul_b = xr_ff; end
         S_M_YY: begin mul_a = 41'(yr_ff); mul_b = yr_ff; end
         S_M_V: begin mul_a = 41'({1'b0, rho_ff}); mul_b = 27'(cfg.gain_rho); end
         S_M_WA: begin
            mul_a = (rho_ff == '0) ? 41'(neg_theta) : 41'(alpha_ff);
            mul_b = 27'(cfg.gain_alpha);
         end
         S_M_WB: begin mul_a = 41'(beta_ff); mul_b = 27'(cfg.gain_beta); end
         S_M_LA: begin mul_a = 41'({1'b0, aw}); mul_b = 27'({1'b0, cfg.linear_limit}); end
         S_M_AV: begin mul_a = 41'({1'b0, av}); mul_b = 27'({1'b0, cfg.angular_limit}); end
         S_M_NUM: begin
            mul_a = usev_ff ? 41'({1'b0, aw}) : 41'({1'b0, av});
            mul_b = usev_ff ? 27'({1'b0, cfg.linear_limit})
                            : 27'({1'b0, cfg.angular_limit});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      st_in = st_ff; ret_in = ret_ff; ent_in = ent_ff; ang_in = ang_ff;
      cx_in = cx_ff; cy_in = cy_ff; cz_in = cz_ff; it_in = it_ff;
      flip_in = flip_ff; c_in = c_ff; s_in = s_ff; acc_in = acc_ff;
      xr_in = xr_ff; yr_in = yr_ff; sn_in = sn_ff; sr_in = sr_ff; sb_in = sb_ff;
      rho_in = rho_ff; dz_in = dz_ff; ax_in = ax_ff; ay_in = ay_ff;
      alpha_in = alpha_ff; beta_in = beta_ff; neg_in = neg_ff; usev_in = usev_ff;
      v_in = v_ff; w_in = w_ff; quo_in = quo_ff; rem_in = rem_ff; den_in = den_ff;
      dc_in = dc_ff; out_in = out_ff;
      ov_in = ov_ff & rsp_stall;
      rsum = '0;
      alpha_w = '0;
      dz_new = dz_ff;
      case (st_ff)
         S_IDLE: begin
            if (pop) begin
               ent_in = q_head;
               if (!q_head.active) begin
                  out_in.linear_velocity = '0;
                  out_in.angular_velocity = '0;
                  out_in.in_deadzone = dz_ff;
                  out_in.was_scaled = 1'b0;
                  ov_in = 1'b1;
               end else begin
                  ang_in = 40'(cfg.goal_heading) <<< 18;
                  ret_in = S_SC_FOLD;
                  st_in = S_WRAP;
               end
            end
         end
         S_WRAP: begin
            if (ang_ff >= ANG_TWO_PI) begin
               ang_in = ang_ff - ANG_TWO_PI;
            end else if (ang_ff <= -ANG_TWO_PI) begin
               ang_in = ang_ff + ANG_TWO_PI;
            end else begin
               if (ang_ff > ANG_PI) begin
                  ang_in = ang_ff - ANG_TWO_PI;
               end else if (ang_ff <= -ANG_PI) begin
                  ang_in = ang_ff + ANG_TWO_PI;
               end
               st_in = ret_ff;
            end
         end
         S_SC_FOLD: begin
            flip_in = 1'b0;
            cz_in = ang_ff;
            if (ang_ff > ANG_HALF_PI) begin
               cz_in = ang_ff - ANG_PI;
               flip_in = 1'b1;
            end else if (ang_ff < -ANG_HALF_PI) begin
               cz_in = ang_ff + ANG_PI;
               flip_in = 1'b1;
            end
            cx_in = CORDIC_KINV;
            cy_in = '0;
            it_in = '0;
            st_in = S_SC_IT;
         end
         S_SC_IT: begin
            if (cz_ff >= 0) begin
               cx_in = cx_ff - (cy_ff >>> it_ff);
               cy_in = cy_ff + (cx_ff >>> it_ff);
               cz_in = cz_ff - tab;
            end else begin
               cx_in = cx_ff + (cy_ff >>> it_ff);
               cy_in = cy_ff - (cx_ff >>> it_ff);
               cz_in = cz_ff + tab;
            end
            it_in = it_ff + 5'd1;
            if (last_it) begin
               st_in = S_SC_END;
            end
         end
         S_SC_END: begin
            c_in = flip_ff ? -cx_ff : cx_ff;
            s_in = flip_ff ? -cy_ff : cy_ff;
            st_in = S_M_CDX;
         end
         S_M_CDX: begin acc_in = prod; st_in = S_M_SDY; end
         S_M_SDY: begin
            rsum = acc_ff + prod + 68'sd536870912;
            xr_in = 27'(rsum >>> 30);
            st_in = S_M_CDY;
         end
         S_M_CDY: begin acc_in = prod; st_in = S_M_SDX; end
         S_M_SDX: begin
            rsum = acc_ff - prod + 68'sd536870912;
            yr_in = 27'(rsum >>> 30);
            st_in = S_M_XX;
         end
         S_M_XX: begin acc_in = prod; st_in = S_M_YY; end
         S_M_YY: begin
            sn_in = 56'(acc_ff + prod);
            sr_in = '0;
            sb_in = SQ_START;
            st_in = S_SQRT;
         end
         S_SQRT: begin
            if (sn_ff >= sq_try) begin
               sn_in = sn_ff - sq_try;
               sr_in = (sr_ff >> 1) + sb_ff;
            end else begin
               sr_in = sr_ff >> 1;
            end
            sb_in = sb_ff >> 2;
            if (sb_ff == 56'd1) begin
               rho_in = 27'(sr_in);
               st_in = S_DZ;
            end
         end
         S_DZ: begin
            if (rho_ff <= 27'd1310) begin
               dz_new = 1'b1;
            end else if (rho_ff >= 27'd3277) begin
               dz_new = 1'b0;
            end
            dz_in = dz_new;
            if (dz_new) begin
               rho_in = '0;
            end
            neg_in = 1'b0;
            if ((xr_ff >= -27'sd65) && (xr_ff <= 27'sd65)) begin
               ang_in = neg_theta;
               ret_in = S_PARK;
               st_in = S_WRAP;
            end else begin
               it_in = '0;
               if (ax0 < 0) begin
                  cz_in = (ay0 >= 0) ? ANG_PI : -ANG_PI;
                  ax_in = -ax0;
                  ay_in = -ay0;
               end else begin
                  cz_in = '0;
                  ax_in = ax0;
                  ay_in = ay0;
               end
               st_in = S_AT_IT;
            end
         end
         S_AT_IT: begin
            if (ay_ff > 0) begin
               ax_in = ax_ff + (ay_ff >>> it_ff);
               ay_in = ay_ff - (ax_ff >>> it_ff);
               cz_in = cz_ff + tab;
            end else if (ay_ff < 0) begin
               ax_in = ax_ff - (ay_ff >>> it_ff);
               ay_in = ay_ff + (ax_ff >>> it_ff);
               cz_in = cz_ff - tab;
            end
            it_in = it_ff + 5'd1;
            if (last_it) begin
               ang_in = neg_theta + cz_in;
               ret_in = S_PARK;
               st_in = S_WRAP;
            end
         end
         S_PARK: begin
            alpha_w = ang_ff;
            if (!(ang_ff <= ANG_HALF_PI && ang_ff > -ANG_HALF_PI)) begin
               neg_in = 1'b1;
               alpha_w = (ang_ff > ANG_HALF_PI) ? ang_ff - ANG_PI : ang_ff + ANG_PI;
            end
            alpha_in = alpha_w;
            ang_in = neg_theta - alpha_w;
            ret_in = S_BETA;
            st_in = S_WRAP;
         end
         S_BETA: begin beta_in = ang_ff; st_in = S_M_V; end
         S_M_V: begin
            rsum = prod + 68'sd128;
            v_in = neg_ff ? -36'(rsum >>> 8) : 36'(rsum >>> 8);
            st_in = S_M_WA;
         end
         S_M_WA: begin
            if (rho_ff == '0) begin
               rsum = prod + 68'sd2097152;
               w_in = 36'(rsum >>> 22);
               st_in = S_SAT;
            end else begin
               acc_in = prod;
               st_in = S_M_WB;
            end
         end
         S_M_WB: begin
            rsum = acc_ff + prod + 68'sd2097152;
            w_in = 36'(rsum >>> 22);
            st_in = S_SAT;
         end
         S_SAT: begin
            if (aw > 36'(cfg.angular_limit) || av > 36'(cfg.linear_limit)) begin
               st_in = S_M_LA;
            end else begin
               out_in.linear_velocity = 24'(v_ff);
               out_in.angular_velocity = 24'(w_ff);
               out_in.in_deadzone = dz_ff;
               out_in.was_scaled = 1'b0;
               ov_in = 1'b1;
               st_in = S_IDLE;
            end
         end
         S_M_LA: begin acc_in = prod; st_in = S_M_AV; end
         S_M_AV: begin
            if (av == '0) begin
               usev_in = 1'b0;
            end else if (aw == '0) begin
               usev_in = 1'b1;
            end else begin
               usev_in = (acc_ff <= prod);
            end
            st_in = S_M_NUM;
         end
         S_M_NUM: begin
            quo_in = 57'(prod);
            rem_in = '0;
            den_in = usev_ff ? av : aw;
            dc_in = DIV_BITS;
            st_in = S_DIV;
         end
         S_DIV: begin
            if (rem_sh >= {1'b0, den_ff}) begin
               rem_in = rem_sh - {1'b0, den_ff};
               quo_in = {quo_ff[55:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quo_in = {quo_ff[55:0], 1'b0};
            end
            dc_in = dc_ff - 6'd1;
            if (dc_ff == 6'd1) begin
               st_in = S_FIN;
            end
         end
         S_FIN: begin
            if (usev_ff) begin
               out_in.angular_velocity = 24'(w_ff[35] ? -quo_s : quo_s);
               out_in.linear_velocity = v_ff[35] ? -24'(cfg.linear_limit)
                                                 : 24'(cfg.linear_limit);
            end else begin
               out_in.linear_velocity = 24'(v_ff[35] ? -quo_s : quo_s);
               out_in.angular_velocity = w_ff[35] ? -24'(cfg.angular_limit)
                                                  : 24'(cfg.angular_limit);
            end
            out_in.in_deadzone = dz_ff;
            out_in.was_scaled = 1'b1;
            ov_in = 1'b1;
            st_in = S_IDLE;
         end
         default: begin
            st_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         dz_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         dz_ff <= dz_in;
         ov_ff <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff <= ret_in; ent_ff <= ent_in; ang_ff <= ang_in;
      cx_ff <= cx_in; cy_ff <= cy_in; cz_ff <= cz_in; it_ff <= it_in;
      flip_ff <= flip_in; c_ff <= c_in; s_ff <= s_in; acc_ff <= acc_in;
      xr_ff <= xr_in; yr_ff <= yr_in; sn_ff <= sn_in; sr_ff <= sr_in; sb_ff <= sb_in;
      rho_ff <= rho_in; ax_ff <= ax_in; ay_ff <= ay_in;
      alpha_ff <= alpha_in; beta_ff <= beta_in; neg_ff <= neg_in; usev_ff <= usev_in;
      v_ff <= v_in; w_ff <= w_in; quo_ff <= quo_in; rem_ff <= rem_in;
      den_ff <= den_in; dc_ff <= dc_in; out_ff <= out_in;
   end
endmodule
`default_nettype wire

FILE: rtl/polar_pose_docking_controller_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Polar-coordinate docking controller: each pose item yields one velocity item.
// A front stage and a two-entry queue take items every cycle until the queue
// fills; the back sequencer then works one item at a time. An active item runs
// a CORDIC rotation, a CORDIC vectoring run that is skipped when the rotated x is
// near zero (TRIG_ITERATIONS steps each), the 28-step square root and the angle
// wrap loop, with all products on one shared multiplier; when saturation scaling
// applies, the bit-serial 57-bit divider runs as well.
module polar_pose_docking_controller_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire ppdc_pkg::req_type  req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output ppdc_pkg::rsp_type       rsp_data,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [4:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);
   import ppdc_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   logic        wr_en, push, q_full, q_not_empty, pop;
   q_entry_type push_data, q_head;
   logic [24:0] lin_mag, ang_mag;

   assign pready = 1'b1;
   assign wr_en = psel & penable & pwrite & pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (paddr[4:2])
            REG_GAIN_RHO: cfg_in.gain_rho = pwdata[15:0];
            REG_GAIN_ALPHA: cfg_in.gain_alpha = pwdata[15:0];
            REG_GAIN_BETA: cfg_in.gain_beta = pwdata[15:0];
            REG_LINEAR_LIMIT: cfg_in.linear_limit = pwdata[22:0];
            REG_ANGULAR_LIMIT: cfg_in.angular_limit = pwdata[22:0];
            REG_GOAL_X: cfg_in.goal_x = pwdata[23:0];
            REG_GOAL_Y: cfg_in.goal_y = pwdata[23:0];
            REG_GOAL_HEADING: cfg_in.goal_heading = pwdata[15:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         REG_GAIN_RHO: prdata = {16'd0, cfg_ff.gain_rho};
         REG_GAIN_ALPHA: prdata = {16'd0, cfg_ff.gain_alpha};
         REG_GAIN_BETA: prdata = {16'd0, cfg_ff.gain_beta};
         REG_LINEAR_LIMIT: prdata = {9'd0, cfg_ff.linear_limit};
         REG_ANGULAR_LIMIT: prdata = {9'd0, cfg_ff.angular_limit};
         REG_GOAL_X: prdata = {8'd0, cfg_ff.goal_x};
         REG_GOAL_Y: prdata = {8'd0, cfg_ff.goal_y};
         REG_GOAL_HEADING: prdata = {16'd0, cfg_ff.goal_heading};
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_rho <= '0;
         cfg_ff.gain_alpha <= '0;
         cfg_ff.gain_beta <= '0;
         cfg_ff.linear_limit <= 23'd131072;
         cfg_ff.angular_limit <= 23'd411775;
         cfg_ff.goal_x <= '0;
         cfg_ff.goal_y <= '0;
         cfg_ff.goal_heading <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ppdc_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .q_full    (q_full),
      .push      (push),
      .entry     (push_data)
   );

   ppdc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   ppdc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   assign lin_mag = 25'(rsp_data.linear_velocity[23] ? -25'(rsp_data.linear_velocity)
                                                     : 25'(rsp_data.linear_velocity));
   assign ang_mag = 25'(rsp_data.angular_velocity[23] ? -25'(rsp_data.angular_velocity)
                                                      : 25'(rsp_data.angular_velocity));

`ifndef SYNTH
   a_scaled_within_limits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.was_scaled |->
         lin_mag <= {2'b0, cfg_ff.linear_limit} && ang_mag <= {2'b0, cfg_ff.angular_limit})
      else $error("scaled result exceeds a limit");
   a_deadzone_no_motion: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.in_deadzone |-> rsp_data.linear_velocity == '0)
      else $error("linear velocity nonzero inside deadzone");
   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_not_empty && !rsp_valid)
      else $error("sequencer took an item it could not hold");
`endif
endmodule
`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 1ps
module tb;
   import ppdc_pkg::*;

   localparam longint PI_Q30 = 64'sd3373259426;
   localparam longint TWO_PI_Q30 = 64'sd6746518852;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;
   localparam longint KINV_Q30 = 64'sd652032874;
   localparam int N_STEPS = 16;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [4:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   polar_pose_docking_controller_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #10 clock = ~clock;

   longint k_rho, k_alpha, k_beta, lin_lim, ang_lim, gx, gy, ghead;
   bit dz_flag;
   req_type pose_queue[$];
   rsp_type velocity_queue[$];
   int mismatches = 0;
   int poses_sent = 0;
   int cmds_seen = 0;
   int scaled_seen = 0;
   int dz_seen = 0;
   int idle_left = 0;
   int stall_left = 0;
   bit send_hold = 1'b0;

   function automatic longint floor_shift(longint x, int s);
      return x >>> s;
   endfunction

   function automatic longint round_shift(longint x, int s);
      return (x + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint wrap_pi(longint a);
      longint n;
      n = a / TWO_PI_Q30;
      a = a - n * TWO_PI_Q30;
      if (a > PI_Q30) a = a - TWO_PI_Q30;
      else if (a <= -PI_Q30) a = a + TWO_PI_Q30;
      return a;
   endfunction

   function automatic longint atan_step(int i);
      return longint'(atan_entry(5'(i)));
   endfunction

   task automatic rotate_cordic(input longint a, output longint c, output longint s);
      longint x, y, z, t;
      bit flip;
      x = KINV_Q30; y = 0; flip = 1'b0;
      a = wrap_pi(a);
      if (a > HALF_PI_Q30) begin a = a - PI_Q30; flip = 1'b1; end
      else if (a < -HALF_PI_Q30) begin a = a + PI_Q30; flip = 1'b1; end
      z = a;
      for (int i = 0; i < N_STEPS; i++) begin
         t = x;
         if (z >= 0) begin
            x = x - floor_shift(y, i); y = y + floor_shift(t, i); z = z - atan_step(i);
         end else begin
            x = x + floor_shift(y, i); y = y - floor_shift(t, i); z = z + atan_step(i);
         end
      end
      if (flip) begin x = -x; y = -y; end
      c = x; s = y;
   endtask

   function automatic longint vector_atan2(longint yv, longint xv);
      longint x, y, z, base, t;
      x = xv * 65536; y = yv * 65536; z = 0; base = 0;
      if (x < 0) begin
         base = (y >= 0) ? PI_Q30 : -PI_Q30;
         x = -x; y = -y;
      end
      for (int i = 0; i < N_STEPS; i++) begin
         t = x;
         if (y > 0) begin
            x = x + floor_shift(y, i); y = y - floor_shift(t, i); z = z + atan_step(i);
         end else if (y < 0) begin
            x = x - floor_shift(y, i); y = y + floor_shift(t, i); z = z - atan_step(i);
         end
      end
      return base + z;
   endfunction

   function automatic longint int_sqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0; b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin n = n - (r + b); r = (r >> 1) + b; end
         else r = r >> 1;
         b = b >> 2;
      end
      return longint'(r);
   endfunction

   task automatic predict_velocity(input req_type p, output rsp_type r);
      longint theta, c, s, dx, dy, xr, yr, rho, alpha, beta, v, w, av, aw;
      bit scaled, use_v;
      r = '0;
      scaled = 1'b0;
      if (!p.active) begin
         r.in_deadzone = dz_flag;
         return;
      end
      theta = (longint'(p.robot_heading) - ghead) * 262144;
      rotate_cordic(ghead * 262144, c, s);
      dx = longint'(p.robot_x) - gx;
      dy = longint'(p.robot_y) - gy;
      xr = round_shift(c * dx + s * dy, 30);
      yr = round_shift(c * dy - s * dx, 30);
      rho = int_sqrt(longint'(xr * xr) + longint'(yr * yr));
      if (rho * 50 < 65536) dz_flag = 1'b1;
      else if (rho * 20 > 65536) dz_flag = 1'b0;
      if (dz_flag) rho = 0;
      if (xr * 1000 < 65536 && xr * 1000 > -65536) alpha = -theta;
      else alpha = -theta + vector_atan2(-yr, -xr);
      alpha = wrap_pi(alpha);
      v = round_shift(k_rho * rho, 8);
      if (!(alpha <= HALF_PI_Q30 && alpha > -HALF_PI_Q30)) begin
         v = -v;
         if (alpha > HALF_PI_Q30) alpha = alpha - PI_Q30;
         else alpha = alpha + PI_Q30;
      end
      beta = wrap_pi(-theta - alpha);
      if (rho == 0) w = round_shift(k_alpha * -theta, 22);
      else w = round_shift(k_alpha * alpha + k_beta * beta, 22);
      av = v < 0 ? -v : v;
      aw = w < 0 ? -w : w;
      if (aw > ang_lim || av > lin_lim) begin
         scaled = 1'b1;
         if (av == 0) use_v = 1'b0;
         else if (aw == 0) use_v = 1'b1;
         else use_v = (lin_lim * aw <= ang_lim * av);
         if (use_v) begin
            w = (w * lin_lim) / av;
            v = v < 0 ? -lin_lim : lin_lim;
         end else begin
            v = (v * ang_lim) / aw;
            w = w < 0 ? -ang_lim : ang_lim;
         end
      end
      r.linear_velocity = v[23:0];
      r.angular_velocity = w[23:0];
      r.in_deadzone = dz_flag;
      r.was_scaled = scaled;
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatches++;
      $display("MISMATCH item %0d %s: got %0d expected %0d", cmds_seen, what, got, want);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall)) begin
         if (idle_left != 0) begin
            idle_left <= idle_left - 1;
            req_valid <= 1'b0;
         end else if (pose_queue.size() != 0 && !send_hold && $urandom_range(0, 3) != 0) begin
            req_valid <= 1'b1;
            req_data <= pose_queue.pop_front();
            if ($urandom_range(0, 49) == 0) idle_left <= $urandom_range(50, 300);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 9) < 3);
         if ($urandom_range(0, 199) == 0) stall_left <= $urandom_range(50, 300);
      end
   end

   // accepted-input predictor and output monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && req_valid && !req_stall) begin
         predict_velocity(req_data, want);
         velocity_queue.push_back(want);
         poses_sent++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         cmds_seen++;
         if (rsp_data.was_scaled) scaled_seen++;
         if (rsp_data.in_deadzone) dz_seen++;
         if (velocity_queue.size() == 0) begin
            report_mismatch("unexpected item at output", 1, 0);
         end else begin
            want = velocity_queue.pop_front();
            if (rsp_data.linear_velocity !== want.linear_velocity)
               report_mismatch("linear_velocity", rsp_data.linear_velocity,
                               want.linear_velocity);
            if (rsp_data.angular_velocity !== want.angular_velocity)
               report_mismatch("angular_velocity", rsp_data.angular_velocity,
                               want.angular_velocity);
            if (rsp_data.in_deadzone !== want.in_deadzone)
               report_mismatch("in_deadzone", rsp_data.in_deadzone, want.in_deadzone);
            if (rsp_data.was_scaled !== want.was_scaled)
               report_mismatch("was_scaled", rsp_data.was_scaled, want.was_scaled);
         end
      end
   end

   task automatic csr_write(input logic [2:0] idx, input longint value);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {idx, 2'b00}; pwdata <= value[31:0];
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         REG_GAIN_RHO: k_rho = longint'($signed(value[15:0]));
         REG_GAIN_ALPHA: k_alpha = longint'($signed(value[15:0]));
         REG_GAIN_BETA: k_beta = longint'($signed(value[15:0]));
         REG_LINEAR_LIMIT: lin_lim = longint'(value[22:0]);
         REG_ANGULAR_LIMIT: ang_lim = longint'(value[22:0]);
         REG_GOAL_X: gx = longint'($signed(value[23:0]));
         REG_GOAL_Y: gy = longint'($signed(value[23:0]));
         REG_GOAL_HEADING: ghead = longint'($signed(value[15:0]));
         default: ghead = longint'($signed(value[15:0]));
      endcase
   endtask

   task automatic drain;
      while (pose_queue.size() != 0 || req_valid || velocity_queue.size() != 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic add_pose(input bit act, input longint x, input longint y, input longint h);
      req_type p;
      p.active = act;
      p.robot_x = x[23:0];
      p.robot_y = y[23:0];
      p.robot_heading = h[15:0];
      pose_queue.push_back(p);
   endtask

   function automatic longint rand_small(int span);
      return longint'($urandom_range(0, 2 * span)) - span;
   endfunction

   task automatic random_poses(input int n);
      longint x, y, h;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 5))
            0: begin x = rand_small(8388607); y = rand_small(8388607); end
            1: begin x = gx + rand_small(4000); y = gy + rand_small(4000); end
            default: begin x = gx + rand_small(300000); y = gy + rand_small(300000); end
         endcase
         if (x > 8388607) x = 8388607;
         if (x < -8388608) x = -8388608;
         if (y > 8388607) y = 8388607;
         if (y < -8388608) y = -8388608;
         h = longint'($urandom_range(0, 65535)) - 32768;
         add_pose($urandom_range(0, 7) != 0, x, y, h);
      end
   endtask

   task automatic random_config;
      csr_write(REG_GAIN_RHO, rand_small(1000));
      csr_write(REG_GAIN_ALPHA, rand_small(2000));
      csr_write(REG_GAIN_BETA, rand_small(1000));
      csr_write(REG_LINEAR_LIMIT, $urandom_range(0, 400000));
      csr_write(REG_ANGULAR_LIMIT, $urandom_range(0, 800000));
      csr_write(REG_GOAL_X, rand_small(2000000));
      csr_write(REG_GOAL_Y, rand_small(2000000));
      csr_write(REG_GOAL_HEADING, rand_small(32768));
   endtask

   initial begin
      k_rho = 0; k_alpha = 0; k_beta = 0;
      lin_lim = 131072; ang_lim = 411775;
      gx = 0; gy = 0; ghead = 0; dz_flag = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      csr_write(REG_GAIN_RHO, 256);
      csr_write(REG_GAIN_ALPHA, 512);
      csr_write(REG_GAIN_BETA, -256);
      csr_write(REG_GOAL_HEADING, 3000);
      add_pose(1, 100000, 50000, 1000);
      drain();

      add_pose(1, 0, 0, 0);
      add_pose(1, 1000, 0, 0);
      add_pose(1, 2500, 0, 0);
      add_pose(1, 4000, 0, 0);
      add_pose(0, 4000, 0, 0);
      add_pose(1, -200000, 30, 12000);
      add_pose(1, -200000, 0, -12000);
      add_pose(1, 20, 300000, 32767);
      add_pose(1, -20, -300000, -32768);
      add_pose(1, 8388607, 8388607, 32767);
      add_pose(1, -8388608, -8388608, -32768);
      add_pose(1, 8388607, -8388608, 0);
      add_pose(0, -8388608, 8388607, -1);
      add_pose(1, 0, -100000, 6434);
      add_pose(1, 50000, 0, -6434);
      drain();

      csr_write(REG_GAIN_RHO, 32767);
      csr_write(REG_GAIN_ALPHA, -32768);
      csr_write(REG_GAIN_BETA, 32767);
      csr_write(REG_LINEAR_LIMIT, 0);
      csr_write(REG_ANGULAR_LIMIT, 8388607);
      csr_write(REG_GOAL_X, 8388607);
      csr_write(REG_GOAL_Y, -8388608);
      csr_write(REG_GOAL_HEADING, -32768);
      add_pose(1, 0, 0, 32767);
      add_pose(1, 8388607, -8388608, 0);
      add_pose(1, -8388608, 8388607, -32768);
      drain();
      csr_write(REG_LINEAR_LIMIT, 8388607);
      csr_write(REG_ANGULAR_LIMIT, 0);
      csr_write(REG_GAIN_BETA, -32768);
      add_pose(1, 0, 0, 100);
      add_pose(1, 12345, -678, -100);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         random_config();
         random_poses(95);
         if (ph == 3) begin
            while (pose_queue.size() > 60) @(posedge clock);
            send_hold <= 1'b1;
            @(posedge clock);
            while (velocity_queue.size() != 0 || req_valid) @(posedge clock);
            send_hold <= 1'b0;
         end
         drain();
      end

      $display("Covered %0d pose items, %0d commands checked", poses_sent, cmds_seen);
      $display("%0d commands scaled, %0d inside the deadzone", scaled_seen, dz_seen);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #200ms;
      $display("Timeout");
      $display("Test completed with failures");
      $finish;
   end
endmodule
